>>> rtl/hma_pkg.sv
// Shared types and constants of the hub memory access unit.
package hma_pkg;

  // Access modes
  localparam logic [2:0] MODE_RD_BYTE = 3'd0;
  localparam logic [2:0] MODE_WR_BYTE = 3'd1;
  localparam logic [2:0] MODE_RD_WORD = 3'd2;
  localparam logic [2:0] MODE_WR_WORD = 3'd3;
  localparam logic [2:0] MODE_RD_LONG = 3'd4;
  localparam logic [2:0] MODE_WR_LONG = 3'd5;
  localparam logic [2:0] MODE_MAP_RD  = 3'd6;
  localparam logic [2:0] MODE_MAP_WR  = 3'd7;

  // Transfer sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;

  // Mapped address windows
  localparam logic [19:0] REG_LIMIT = 20'h00800;
  localparam logic [19:0] LUT_LIMIT = 20'h01000;
  localparam logic [17:0] LUT_BASE  = 18'h00200;

  // Per-core RAM geometry
  localparam int CORE_LONGS = 512;
  localparam int CORE_OFF_W = $clog2(CORE_LONGS);

  // Defaults for the top-level parameters
  localparam int HUB_BYTES_DEF = 524288;
  localparam int MAX_CORES_DEF = 16;

  localparam logic [4:0] ACTIVE_CORES_RST = 5'd16;

  // Memory selected by a request
  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_HUB  = 2'd1,
    TGT_REG  = 2'd2,
    TGT_LUT  = 2'd3
  } tgt_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic capture;
    logic mem_en;
    logic load_out;
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MEM  = 3'b010,
    S_LOAD = 3'b100
  } state_t;

endpackage

>>> rtl/hma_ctrl.sv
// Controller state machine of the hub memory access unit.
module hma_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output hma_pkg::cmd_t cmd
);

  hma_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            load;

  // Load the output register once it is free or being drained
  assign load = (state_r == hma_pkg::S_LOAD) && (!out_valid_r || out_ready);

  assign in_ready     = (state_r == hma_pkg::S_IDLE);
  assign out_valid    = out_valid_r;
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.mem_en   = (state_r == hma_pkg::S_MEM);
  assign cmd.load_out = load;

  // Advance the state machine
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hma_pkg::S_IDLE: begin
        if (in_valid) state_nxt = hma_pkg::S_MEM;
      end
      hma_pkg::S_MEM: begin
        state_nxt = hma_pkg::S_LOAD;
      end
      hma_pkg::S_LOAD: begin
        if (load) state_nxt = hma_pkg::S_IDLE;
      end
      default: begin
        state_nxt = hma_pkg::S_IDLE;
      end
    endcase
  end

  // Set on load, clear on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hma_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A pending result is never overwritten
  a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hma_pkg::S_LOAD && out_valid_r && !out_ready) |=>
      (state_r == hma_pkg::S_LOAD && out_valid_r))
    else $error("pending result overwritten");

  // An accepted access goes to the memory cycle next
  a_capture_mem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == hma_pkg::S_MEM))
    else $error("capture not followed by memory cycle");

  // The memory cycle is always followed by the load state
  a_mem_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hma_pkg::S_MEM) |=> (state_r == hma_pkg::S_LOAD))
    else $error("memory cycle not followed by load");

  // A result appears only after a load
  a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(load))
    else $error("output valid without load");

endmodule

>>> rtl/hma_datapath.sv
// Datapath of the hub memory access unit: decode, memories, read formatting.
module hma_datapath #(
  parameter int HUB_BYTES = hma_pkg::HUB_BYTES_DEF,
  parameter int MAX_CORES = hma_pkg::MAX_CORES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hma_pkg::cmd_t cmd,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_data,
  input  logic [2:0]    in_mode,
  input  logic [3:0]    in_core_id,
  input  logic [19:0]   in_byte_address,
  input  logic [31:0]   in_write_data,
  output logic [31:0]   out_read_data,
  output logic          out_accepted
);

  localparam int HUB_LONGS  = (HUB_BYTES + 3) / 4;
  localparam int HUB_AW     = $clog2(HUB_LONGS);
  localparam int CORE_DEPTH = MAX_CORES * hma_pkg::CORE_LONGS;
  localparam int CORE_AW    = $clog2(CORE_DEPTH);
  localparam int OFF_W      = hma_pkg::CORE_OFF_W;

  // Memories
  logic [31:0] hub_mem [HUB_LONGS];
  logic [31:0] reg_mem [CORE_DEPTH];
  logic [31:0] lut_mem [CORE_DEPTH];

  logic [4:0] active_cores_r;

  // Request registers
  hma_pkg::tgt_t       tgt_r;
  logic                wr_r;
  logic                ok_r;
  logic [1:0]          sz_r;
  logic [1:0]          off_r;
  logic [3:0]          be_r;
  logic [HUB_AW-1:0]   hub_idx_r;
  logic [CORE_AW-1:0]  core_idx_r;
  logic [31:0]         wdata_r;

  logic [31:0] hub_rd_r, reg_rd_r, lut_rd_r;
  logic [31:0] out_read_data_r;
  logic        out_accepted_r;

  // Decode signals
  logic               mapped, hub_ok, core_ok, ok;
  hma_pkg::tgt_t      tgt;
  logic [1:0]         sz, off;
  logic [3:0]         be;
  logic [31:0]        wdata;
  logic [17:0]        long_addr;
  logic [OFF_W-1:0]   core_off;

  logic [31:0] rd_word, rd_shift, rd_fmt;

  // Hold the core count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_cores_r <= hma_pkg::ACTIVE_CORES_RST;
    end else if (cfg_we) begin
      active_cores_r <= cfg_data;
    end
  end

  // Decode the incoming access
  always_comb begin
    mapped    = (in_mode == hma_pkg::MODE_MAP_RD) || (in_mode == hma_pkg::MODE_MAP_WR);
    hub_ok    = {1'b0, in_byte_address} < 21'(HUB_BYTES);
    core_ok   = ({1'b0, in_core_id} < active_cores_r) && (5'(in_core_id) < 5'(MAX_CORES));
    long_addr = in_byte_address[19:2];
    tgt       = hma_pkg::TGT_NONE;
    core_off  = long_addr[OFF_W-1:0];
    if (!mapped) begin
      if (hub_ok) tgt = hma_pkg::TGT_HUB;
    end else if (core_ok) begin
      if (in_byte_address < hma_pkg::REG_LIMIT) begin
        tgt = hma_pkg::TGT_REG;
      end else if (in_byte_address < hma_pkg::LUT_LIMIT) begin
        tgt      = hma_pkg::TGT_LUT;
        core_off = OFF_W'(long_addr - hma_pkg::LUT_BASE);
      end else if (hub_ok) begin
        tgt = hma_pkg::TGT_HUB;
      end
    end
    ok = (tgt != hma_pkg::TGT_NONE);
    sz = mapped ? hma_pkg::SZ_LONG : in_mode[2:1];
    case (sz)
      hma_pkg::SZ_BYTE: begin
        off   = in_byte_address[1:0];
        be    = 4'b0001 << off;
        wdata = {4{in_write_data[7:0]}};
      end
      hma_pkg::SZ_WORD: begin
        off   = {in_byte_address[1], 1'b0};
        be    = 4'b0011 << off;
        wdata = {2{in_write_data[15:0]}};
      end
      default: begin
        off   = 2'd0;
        be    = 4'b1111;
        wdata = in_write_data;
      end
    endcase
  end

  // Capture the decoded request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= hma_pkg::TGT_NONE;
    end else if (cmd.capture) begin
      tgt_r <= tgt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      wr_r       <= in_mode[0];
      ok_r       <= ok;
      sz_r       <= sz;
      off_r      <= off;
      be_r       <= be;
      hub_idx_r  <= long_addr[HUB_AW-1:0];
      core_idx_r <= CORE_AW'({in_core_id, core_off});
      wdata_r    <= wdata;
    end
  end

  // Hub memory port with byte lanes
  always_ff @(posedge clk) begin
    if (cmd.mem_en && tgt_r == hma_pkg::TGT_HUB) begin
      if (wr_r) begin
        for (int b = 0; b < 4; b++) begin
          if (be_r[b]) hub_mem[hub_idx_r][8*b +: 8] <= wdata_r[8*b +: 8];
        end
      end else begin
        hub_rd_r <= hub_mem[hub_idx_r];
      end
    end
  end

  // Register RAM port
  always_ff @(posedge clk) begin
    if (cmd.mem_en && tgt_r == hma_pkg::TGT_REG) begin
      if (wr_r) reg_mem[core_idx_r] <= wdata_r;
      else reg_rd_r <= reg_mem[core_idx_r];
    end
  end

  // Lookup RAM port
  always_ff @(posedge clk) begin
    if (cmd.mem_en && tgt_r == hma_pkg::TGT_LUT) begin
      if (wr_r) lut_mem[core_idx_r] <= wdata_r;
      else lut_rd_r <= lut_mem[core_idx_r];
    end
  end

  // Select, align and mask the read data
  always_comb begin
    case (tgt_r)
      hma_pkg::TGT_HUB: rd_word = hub_rd_r;
      hma_pkg::TGT_REG: rd_word = reg_rd_r;
      hma_pkg::TGT_LUT: rd_word = lut_rd_r;
      default:          rd_word = 32'd0;
    endcase
    rd_shift = rd_word >> {off_r, 3'b000};
    case (sz_r)
      hma_pkg::SZ_BYTE: rd_fmt = {24'd0, rd_shift[7:0]};
      hma_pkg::SZ_WORD: rd_fmt = {16'd0, rd_shift[15:0]};
      default:          rd_fmt = rd_shift;
    endcase
    if (wr_r || !ok_r) rd_fmt = 32'd0;
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_data_r <= rd_fmt;
      out_accepted_r  <= ok_r;
    end
  end

  assign out_read_data = out_read_data_r;
  assign out_accepted  = out_accepted_r;

endmodule

>>> rtl/hub_memory_access_unit.sv
// Top level of the hub memory access unit.
//
// Serves byte, word and long reads and writes of a shared little-endian hub
// memory, plus mapped long accesses that reach a core's register RAM, its
// lookup RAM or the hub memory depending on the address.
// Channels: in_* carries one access (mode, core, byte address, write data)
// under valid/ready; out_* returns one result per access (read data and an
// accepted flag) under valid/ready; cfg_* writes the active core count and
// is always ready; write it only while no access is in flight.
// Path: an accepted access is registered, its memory port is accessed,
// then the read data is aligned and loaded into the output register.
// Accesses do not overlap: a new access is taken only in idle, after the
// controller's capture-access-load sequence has loaded the previous result.
// A new access may be taken while the previous result still waits.
// Reset: clears the controller and sets the active core count to 16; the
// memories are not cleared and must be written before they are read.
// Receiver stall: the result holds in the output register; the next access
// finishes its memory cycle and then waits until the result is taken.
module hub_memory_access_unit #(
  parameter int HUB_BYTES = hma_pkg::HUB_BYTES_DEF,
  parameter int MAX_CORES = hma_pkg::MAX_CORES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_core_id,
  input  logic [19:0] in_byte_address,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_accepted
);

  hma_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  hma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  hma_datapath #(
    .HUB_BYTES (HUB_BYTES),
    .MAX_CORES (MAX_CORES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .in_mode         (in_mode),
    .in_core_id      (in_core_id),
    .in_byte_address (in_byte_address),
    .in_write_data   (in_write_data),
    .out_read_data   (out_read_data),
    .out_accepted    (out_accepted)
  );

endmodule
